// ===== src/sliu_pkg.sv =====
`timescale 1ns / 1ps

package sliu_pkg;

    localparam int unsigned VEC_W  = 128;
    localparam int unsigned HALF_W = 64;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned NWORDS = VEC_W / WORD_W;
    localparam int unsigned WIDX_W = $clog2(NWORDS);
    localparam int unsigned SH_W   = 6;

    typedef enum logic [3:0] {
        OP_PTEST      = 4'd0,
        OP_PHMINPOS   = 4'd1,
        OP_EXTR_B     = 4'd2,
        OP_EXTR_W     = 4'd3,
        OP_EXTR_D     = 4'd4,
        OP_EXTR_Q     = 4'd5,
        OP_INS_B      = 4'd6,
        OP_INS_W      = 4'd7,
        OP_INS_D      = 4'd8,
        OP_INS_Q      = 4'd9,
        OP_INSPS      = 4'd10,
        OP_INSPS_SC   = 4'd11,
        OP_EXTRQ_IMM  = 4'd12,
        OP_EXTRQ_CTRL = 4'd13,
        OP_INSQ_IMM   = 4'd14,
        OP_INSQ_CTRL  = 4'd15
    } op_t;

endpackage

// ===== src/simd_lane_insert_extract_unit.sv =====
`timescale 1ns / 1ps

// SIMD lane unit: 128-bit integer lane operations (test, horizontal word
// minimum, lane extract and insert, insertps, and qword bit-field extract
// and insert).
// The request channel carries one instruction per transfer: opcode, the
// destination and source vectors as two 64-bit halves each, a scalar and
// two immediates. A transfer happens when req_valid is high and req_stall
// is low. The response channel returns the new destination vector, the
// extracted scalar and the two test flags under rsp_valid / rsp_stall.
// The request is registered in stage 1, then stage 2, then stage 3, whose
// register drives the response; the unit takes a new request every cycle
// while req_stall is low, so sustained throughput is one instruction per
// cycle, set by the three-stage register pipeline.
// Each stage advances when the stage after it is empty or moving, so empty
// slots close up while the receiver stalls; req_stall rises only when all
// three stages hold an instruction and the response is stalled. A stalled
// response holds its value. Reset empties the pipeline; the unit has no
// other state.
module simd_lane_insert_extract_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [3:0]  opcode,
    input  logic [63:0] dst_lo,
    input  logic [63:0] dst_hi,
    input  logic [63:0] src_lo,
    input  logic [63:0] src_hi,
    input  logic [63:0] scalar_in,
    input  logic [7:0]  imm_a,
    input  logic [7:0]  imm_b,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] res_lo,
    output logic [63:0] res_hi,
    output logic [63:0] scalar_out,
    output logic        zero_flag,
    output logic        carry_flag
);
    import sliu_pkg::*;

    typedef struct packed {
        op_t                        op;
        logic [VEC_W-1:0]           dst;
        logic [VEC_W-1:0]           src;
        logic [HALF_W-1:0]          sc;
        logic [7:0]                 ia;
        logic [HALF_W-1:0]          sout;
        logic                       zf;
        logic                       cf;
        logic [3:0][WORD_W-1:0]     pm_val;
        logic [3:0][WIDX_W-1:0]     pm_idx;
        logic [SH_W-1:0]            bf_sh;
        logic [HALF_W-1:0]          bf_m;
    } s1_t;

    typedef struct packed {
        op_t                        op;
        logic [VEC_W-1:0]           dst;
        logic [VEC_W-1:0]           lane_vec;
        logic [HALF_W-1:0]          sout;
        logic                       zf;
        logic                       cf;
        logic [1:0][WORD_W-1:0]     pm_val;
        logic [1:0][WIDX_W-1:0]     pm_idx;
        logic [HALF_W-1:0]          bf_m;
        logic [HALF_W-1:0]          bf_msh;
        logic [HALF_W-1:0]          bf_ext;
        logic [HALF_W-1:0]          bf_ins;
    } s2_t;

    typedef struct packed {
        logic [HALF_W-1:0] res_lo;
        logic [HALF_W-1:0] res_hi;
        logic [HALF_W-1:0] sout;
        logic              zf;
        logic              cf;
    } s3_t;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic en1, en2, en3;

    // A stage may load when it is empty or its contents move on this cycle.
    assign en3       = !s3_valid_reg || !rsp_stall;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req_stall = !en1;

    // Stage 1: decode, test flags, lane extract, first round of the word
    // minimum, and bit-field length, shift and mask.
    always_comb
    begin
        logic [VEC_W-1:0]  src_v;
        logic [VEC_W-1:0]  dst_v;
        logic [SH_W-1:0]   len;
        logic [WORD_W-1:0] wa;
        logic [WORD_W-1:0] wb;
        src_v = {src_hi, src_lo};
        dst_v = {dst_hi, dst_lo};
        s1_next.op     = op_t'(opcode);
        s1_next.dst    = dst_v;
        s1_next.src    = src_v;
        s1_next.sc     = scalar_in;
        s1_next.ia     = imm_a;
        s1_next.zf     = 1'b0;
        s1_next.cf     = 1'b0;
        s1_next.sout   = '0;
        s1_next.bf_sh  = imm_b[SH_W-1:0];
        len            = imm_a[SH_W-1:0];

        case (op_t'(opcode))
            OP_PTEST:
            begin
                s1_next.zf = ~|(src_v & dst_v);
                s1_next.cf = ~|(src_v & ~dst_v);
            end
            OP_EXTR_B:
                s1_next.sout = {56'd0, src_v[{imm_a[3:0], 3'd0} +: 8]};
            OP_EXTR_W:
                s1_next.sout = {48'd0, src_v[{imm_a[2:0], 4'd0} +: 16]};
            OP_EXTR_D:
                s1_next.sout = {32'd0, src_v[{imm_a[1:0], 5'd0} +: 32]};
            OP_EXTR_Q:
                s1_next.sout = imm_a[0] ? src_hi : src_lo;
            OP_EXTRQ_CTRL:
            begin
                len           = src_lo[SH_W-1:0];
                s1_next.bf_sh = src_lo[8 +: SH_W];
            end
            OP_INSQ_CTRL:
            begin
                len           = src_hi[SH_W-1:0];
                s1_next.bf_sh = src_hi[8 +: SH_W];
            end
            default:
            begin
            end
        endcase

        // A field length of zero stands for a full 64-bit field.
        s1_next.bf_m = (len == '0) ? '1 : ((64'd1 << len) - 64'd1);

        // Ties keep the lower word index.
        for (int k = 0; k < 4; k++)
        begin
            wa = src_v[(2*k)*WORD_W +: WORD_W];
            wb = src_v[(2*k+1)*WORD_W +: WORD_W];
            if (wb < wa)
            begin
                s1_next.pm_val[k] = wb;
                s1_next.pm_idx[k] = WIDX_W'(2*k+1);
            end
            else
            begin
                s1_next.pm_val[k] = wa;
                s1_next.pm_idx[k] = WIDX_W'(2*k);
            end
        end
    end

    // Stage 2: lane inserts and insertps, bit-field shifts, second round
    // of the word minimum.
    always_comb
    begin
        logic [VEC_W-1:0] v;
        logic [31:0]      ps_val;
        v      = s1_reg.dst;
        ps_val = (s1_reg.op == OP_INSPS) ? s1_reg.src[{s1_reg.ia[7:6], 5'd0} +: 32]
                                         : s1_reg.sc[31:0];
        case (s1_reg.op)
            OP_INS_B:
                v[{s1_reg.ia[3:0], 3'd0} +: 8] = s1_reg.sc[7:0];
            OP_INS_W:
                v[{s1_reg.ia[2:0], 4'd0} +: 16] = s1_reg.sc[15:0];
            OP_INS_D:
                v[{s1_reg.ia[1:0], 5'd0} +: 32] = s1_reg.sc[31:0];
            OP_INS_Q:
                v[{s1_reg.ia[0], 6'd0} +: 64] = s1_reg.sc;
            OP_INSPS, OP_INSPS_SC:
            begin
                v[{s1_reg.ia[5:4], 5'd0} +: 32] = ps_val;
                for (int j = 0; j < 4; j++)
                begin
                    if (s1_reg.ia[j])
                        v[j*32 +: 32] = 32'd0;
                end
            end
            default:
            begin
            end
        endcase

        s2_next.op       = s1_reg.op;
        s2_next.dst      = s1_reg.dst;
        s2_next.lane_vec = v;
        s2_next.sout     = s1_reg.sout;
        s2_next.zf       = s1_reg.zf;
        s2_next.cf       = s1_reg.cf;
        s2_next.bf_m     = s1_reg.bf_m;
        s2_next.bf_msh   = s1_reg.bf_m << s1_reg.bf_sh;
        s2_next.bf_ext   = s1_reg.dst[HALF_W-1:0] >> s1_reg.bf_sh;
        s2_next.bf_ins   = (s1_reg.src[HALF_W-1:0] & s1_reg.bf_m) << s1_reg.bf_sh;

        for (int k = 0; k < 2; k++)
        begin
            if (s1_reg.pm_val[2*k+1] < s1_reg.pm_val[2*k])
            begin
                s2_next.pm_val[k] = s1_reg.pm_val[2*k+1];
                s2_next.pm_idx[k] = s1_reg.pm_idx[2*k+1];
            end
            else
            begin
                s2_next.pm_val[k] = s1_reg.pm_val[2*k];
                s2_next.pm_idx[k] = s1_reg.pm_idx[2*k];
            end
        end
    end

    // Stage 3: last round of the word minimum, bit-field merge, result select.
    always_comb
    begin
        logic [WORD_W-1:0] mv;
        logic [WIDX_W-1:0] mi;
        if (s2_reg.pm_val[1] < s2_reg.pm_val[0])
        begin
            mv = s2_reg.pm_val[1];
            mi = s2_reg.pm_idx[1];
        end
        else
        begin
            mv = s2_reg.pm_val[0];
            mi = s2_reg.pm_idx[0];
        end

        s3_next.sout   = s2_reg.sout;
        s3_next.zf     = s2_reg.zf;
        s3_next.cf     = s2_reg.cf;
        s3_next.res_lo = s2_reg.lane_vec[HALF_W-1:0];
        s3_next.res_hi = s2_reg.lane_vec[VEC_W-1:HALF_W];

        case (s2_reg.op)
            OP_PHMINPOS:
            begin
                s3_next.res_lo = {{(HALF_W-WORD_W-WIDX_W){1'b0}}, mi, mv};
                s3_next.res_hi = '0;
            end
            OP_EXTRQ_IMM, OP_EXTRQ_CTRL:
            begin
                s3_next.res_lo = s2_reg.bf_ext & s2_reg.bf_m;
                s3_next.res_hi = s2_reg.dst[VEC_W-1:HALF_W];
            end
            OP_INSQ_IMM, OP_INSQ_CTRL:
            begin
                s3_next.res_lo = (s2_reg.dst[HALF_W-1:0] & ~s2_reg.bf_msh) | s2_reg.bf_ins;
                s3_next.res_hi = s2_reg.dst[VEC_W-1:HALF_W];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= req_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req_valid)
            s1_reg <= s1_next;
        if (en2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (en3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

    assign rsp_valid  = s3_valid_reg;
    assign res_lo     = s3_reg.res_lo;
    assign res_hi     = s3_reg.res_hi;
    assign scalar_out = s3_reg.sout;
    assign zero_flag  = s3_reg.zf;
    assign carry_flag = s3_reg.cf;

endmodule

// ===== src/sliu_checker.sv =====
`timescale 1ns / 1ps

module sliu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [63:0] res_lo,
    input logic [63:0] res_hi,
    input logic [63:0] scalar_out,
    input logic        zero_flag,
    input logic        carry_flag
);

    // A stalled response stays valid.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its value.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(res_lo) && $stable(res_hi)
            && $stable(scalar_out) && $stable(zero_flag) && $stable(carry_flag))
        else $error("response changed while stalled");

    // Once reset has been seen at a clock edge, the pipeline is empty.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("response valid during reset");

    // Requests are held back only when the pipeline is full behind a stalled response.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled with room in the pipeline");

    // Only the test operation sets a flag, and it extracts nothing.
    a_flags_no_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (zero_flag || carry_flag) |-> scalar_out == 64'd0)
        else $error("flags set together with an extracted scalar");

endmodule

bind simd_lane_insert_extract_unit sliu_checker u_sliu_checker (.*);
